[sv/nfad_pkg.sv]
// Shared types and constants for the NFA to DFA subset construction block.
// No dependencies; imported by the top level.
`default_nettype none

package nfad_pkg;

    // Command codes carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_RUN  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // Payload widths that the stream fields fix.
    localparam int unsigned MASK_W   = 8;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 40;
    localparam logic [3:0]  CFG_RESET  = 4'd8;

endpackage

`default_nettype wire

[sv/nfad_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module nfad_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/nfa_to_dfa_subset_construction.sv]
// Top level of the NFA to DFA subset construction block.
// Depends on nfad_pkg and nfad_ram.
`default_nettype none

// Loads an NFA over the alphabet {0,1} one row per transfer, converts it to a DFA by
// breadth-first subset construction on a run command, and returns one DFA row per read
// command. Every command produces exactly one result transfer. A load or an unused command
// is answered straight from idle; a read first waits for the registered RAM read data.
// Once the run transfer is accepted, the run sweeps all 2**MAX_NFA_STATES entries of the
// subset number map, one entry a cycle. It then seeds subset {state 0} and takes five steps
// per DFA state found (subset table read, row OR with the zero-successor lookup,
// zero-successor numbering, one-successor lookup, one-successor numbering, all on
// single-port-read RAMs), and closes with a final queue check that sends the result.
// The NFA rows sit in flip-flops; the map, the subset table and the transition table sit in
// synchronous RAMs. Only one command is in work at a time.
module nfa_to_dfa_subset_construction
    import nfad_pkg::*;
#(
    parameter int unsigned MAX_NFA_STATES = 8,
    parameter int unsigned MAX_DFA_STATES = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata: row_index[7:0], next_on_zero_mask[15:8], next_on_one_mask[23:16],
    //        is_accepting[24], zero fill[31:25]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // tuser: command[1:0]
    input  wire logic [1:0]            s_tuser,
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // tdata: subset_mask[7:0], dfa_next_zero[15:8], dfa_next_one[23:16],
    //        dfa_accepting[24], dfa_state_count[33:25], row_valid[34], zero fill[39:35]
    output logic      [OUT_DATA_W-1:0] m_tdata,
    // Configuration: nfa_state_count.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [3:0]            cfg_data
);

    localparam int unsigned N     = MAX_NFA_STATES;
    localparam int unsigned D     = MAX_DFA_STATES;
    localparam int unsigned SPACE = 1 << N;
    localparam int unsigned AW    = $clog2(D);
    localparam int unsigned CW    = $clog2(D + 1);
    localparam int unsigned IW    = $clog2(N);
    localparam int unsigned MW    = CW + 1;
    localparam int unsigned TW    = 2 * MASK_W + 1;
    localparam logic [CW-1:0]      D_COUNT  = CW'(D);
    localparam logic [CW-1:0]      D_LAST   = CW'(D - 1);
    localparam logic [CW+7:0]      D_WIDE   = (CW + 8)'(D);
    localparam logic [7:0]         N_LIMIT  = 8'(N);
    localparam logic [3:0]         N_CFG    = 4'(N);
    localparam logic [N-1:0]       SEED_SET = N'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SEED,
        ST_FETCH,
        ST_EXPAND,
        ST_NUM_Z,
        ST_LOOK_O,
        ST_NUM_O,
        ST_READ_WAIT
    } state_t;

    state_t                state_reg, state_next;
    logic [3:0]            cfg_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         head_reg, head_next;
    logic [N-1:0]          clr_reg, clr_next;
    logic [N-1:0]          z_reg, z_next;
    logic [N-1:0]          o_reg, o_next;
    logic                  acc_reg, acc_next;
    logic [7:0]            nz_reg, nz_next;
    logic                  hit_reg, hit_next;
    logic [N-1:0]          zero_rows_reg [N];
    logic [N-1:0]          one_rows_reg [N];
    logic [N-1:0]          accept_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // Input field decode.
    cmd_t                  cmd;
    logic [7:0]            in_idx;
    logic [7:0]            in_m0;
    logic [7:0]            in_m1;
    logic                  in_acc;
    logic                  in_xfer;
    logic                  load_ok;
    logic [N+7:0]          m0_wide;
    logic [N+7:0]          m1_wide;
    logic [AW+7:0]         idx_wide;
    logic [CW+7:0]         idx_cmp;
    logic [CW+7:0]         count_cmp;
    logic                  read_ok;

    // Memory ports.
    logic                  map_we;
    logic [N-1:0]          map_waddr;
    logic [MW-1:0]         map_wdata;
    logic [N-1:0]          map_raddr;
    logic [MW-1:0]         map_rdata;
    logic                  sub_we;
    logic [AW-1:0]         sub_waddr;
    logic [N-1:0]          sub_wdata;
    logic [AW-1:0]         sub_raddr;
    logic [N-1:0]          sub_rdata;
    logic                  tr_we;
    logic [TW-1:0]         tr_wdata;
    logic [TW-1:0]         tr_rdata;

    // Run datapath.
    logic [3:0]            n_use;
    logic [N-1:0]          use_mask;
    logic [N-1:0]          z_comb;
    logic [N-1:0]          o_comb;
    logic [N-1:0]          tgt;
    logic [CW-1:0]         num;
    logic [CW+7:0]         num_wide;
    logic                  add_new;
    logic [N+7:0]          sm_wide;
    logic [CW+8:0]         cnt_wide;

    assign cmd      = cmd_t'(s_tuser);
    assign in_idx   = s_tdata[7:0];
    assign in_m0    = s_tdata[15:8];
    assign in_m1    = s_tdata[23:16];
    assign in_acc   = s_tdata[24];
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign in_xfer  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign load_ok   = in_idx < N_LIMIT;
    assign m0_wide   = {{N{1'b0}}, in_m0};
    assign m1_wide   = {{N{1'b0}}, in_m1};
    assign idx_wide  = {{AW{1'b0}}, in_idx};
    assign idx_cmp   = {{CW{1'b0}}, in_idx};
    assign count_cmp = {8'b0, count_reg};
    assign read_ok   = (idx_cmp < count_cmp) && (idx_cmp < D_WIDE);
    assign cnt_wide  = {9'b0, count_reg};

    // Clamp the configured state count and build the in-use mask.
    always_comb
    begin
        n_use = cfg_reg;
        if (cfg_reg == 4'd0)
        begin
            n_use = 4'd1;
        end
        else if (cfg_reg > N_CFG)
        begin
            n_use = N_CFG;
        end
        for (int i = 0; i < N; i++)
        begin
            use_mask[i] = 4'(i) < n_use;
        end
    end

    // Successor sets of the fetched subset: OR of the member rows.
    always_comb
    begin
        z_comb = '0;
        o_comb = '0;
        for (int i = 0; i < N; i++)
        begin
            if (sub_rdata[i] && use_mask[i])
            begin
                z_comb = z_comb | zero_rows_reg[i];
                o_comb = o_comb | one_rows_reg[i];
            end
        end
        z_comb = z_comb & use_mask;
        o_comb = o_comb & use_mask;
    end

    // Numbering of a looked-up successor set.
    assign tgt = (state_reg == ST_NUM_Z) ? z_reg : o_reg;
    always_comb
    begin
        add_new = 1'b0;
        if (map_rdata[CW])
        begin
            num = map_rdata[CW-1:0];
        end
        else if (count_reg == D_COUNT)
        begin
            num = D_LAST;
        end
        else
        begin
            num     = count_reg;
            add_new = 1'b1;
        end
    end
    assign num_wide = {8'b0, num};
    assign sm_wide  = {8'b0, sub_rdata};

    // Next-state logic and memory control.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        clr_next     = clr_reg;
        z_next       = z_reg;
        o_next       = o_reg;
        acc_next     = acc_reg;
        nz_next      = nz_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        map_we       = 1'b0;
        map_waddr    = clr_reg;
        map_wdata    = '0;
        map_raddr    = z_comb;
        sub_we       = 1'b0;
        sub_waddr    = count_reg[AW-1:0];
        sub_wdata    = tgt;
        sub_raddr    = head_reg[AW-1:0];
        tr_we        = 1'b0;
        tr_wdata     = {acc_reg, num_wide[7:0], nz_reg};

        unique case (state_reg) inside
            ST_IDLE:
            begin
                sub_raddr = idx_wide[AW-1:0];
                if (in_xfer)
                begin
                    unique case (cmd) inside
                        CMD_RUN:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            hit_next   = read_ok;
                            state_next = ST_READ_WAIT;
                        end
                        CMD_LOAD, CMD_NONE:
                        begin
                            m_valid_next = 1'b1;
                            m_data_next  = {5'b0, 1'b0, cnt_wide[8:0], 25'b0};
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                map_we   = 1'b1;
                clr_next = clr_reg + N'(1);
                if (clr_reg == N'(SPACE - 1))
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                map_we     = 1'b1;
                map_waddr  = SEED_SET;
                map_wdata  = {1'b1, CW'(0)};
                sub_we     = 1'b1;
                sub_waddr  = '0;
                sub_wdata  = SEED_SET;
                count_next = CW'(1);
                head_next  = '0;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                if (head_reg < count_reg)
                begin
                    state_next = ST_EXPAND;
                end
                else
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'b0, 1'b0, cnt_wide[8:0], 25'b0};
                    state_next   = ST_IDLE;
                end
            end
            ST_EXPAND:
            begin
                z_next     = z_comb;
                o_next     = o_comb;
                acc_next   = |(sub_rdata & accept_reg & use_mask);
                state_next = ST_NUM_Z;
            end
            ST_NUM_Z, ST_NUM_O:
            begin
                if (add_new)
                begin
                    map_we     = 1'b1;
                    map_waddr  = tgt;
                    map_wdata  = {1'b1, count_reg};
                    sub_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                if (state_reg == ST_NUM_Z)
                begin
                    nz_next    = num_wide[7:0];
                    state_next = ST_LOOK_O;
                end
                else
                begin
                    tr_we      = 1'b1;
                    head_next  = head_reg + CW'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_LOOK_O:
            begin
                map_raddr  = o_reg;
                state_next = ST_NUM_O;
            end
            ST_READ_WAIT:
            begin
                m_valid_next = 1'b1;
                if (hit_reg)
                begin
                    m_data_next = {5'b0, 1'b1, cnt_wide[8:0], tr_rdata, sm_wide[7:0]};
                end
                else
                begin
                    m_data_next = {5'b0, 1'b0, cnt_wide[8:0], 25'b0};
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters, NFA rows and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= CFG_RESET;
            count_reg   <= '0;
            head_reg    <= '0;
            clr_reg     <= '0;
            accept_reg  <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                zero_rows_reg[i] <= '0;
                one_rows_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
            if (in_xfer && (cmd == CMD_LOAD) && load_ok)
            begin
                zero_rows_reg[in_idx[IW-1:0]] <= m0_wide[N-1:0];
                one_rows_reg[in_idx[IW-1:0]]  <= m1_wide[N-1:0];
                accept_reg[in_idx[IW-1:0]]    <= in_acc;
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        z_reg      <= z_next;
        o_reg      <= o_next;
        acc_reg    <= acc_next;
        nz_reg     <= nz_next;
        hit_reg    <= hit_next;
        m_data_reg <= m_data_next;
    end

    // Subset number map: valid bit and DFA number per subset.
    nfad_ram #(
        .WIDTH (MW),
        .DEPTH (SPACE)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Subset table: NFA set of each DFA state, also the work queue.
    nfad_ram #(
        .WIDTH (N),
        .DEPTH (D)
    ) u_subset (
        .clk   (clk),
        .we    (sub_we),
        .waddr (sub_waddr),
        .wdata (sub_wdata),
        .raddr (sub_raddr),
        .rdata (sub_rdata)
    );

    // Transition table: accept bit and both successor numbers.
    nfad_ram #(
        .WIDTH (TW),
        .DEPTH (D)
    ) u_trans (
        .clk   (clk),
        .we    (tr_we),
        .waddr (head_reg[AW-1:0]),
        .wdata (tr_wdata),
        .raddr (idx_wide[AW-1:0]),
        .rdata (tr_rdata)
    );

`ifndef SYNTHESIS
    // The DFA state count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= D_COUNT)
        else $error("DFA state count exceeds table depth");

    // The queue head never overtakes the number of states found during a run.
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> (head_reg <= count_reg))
        else $error("queue head passed the DFA state count");

    // A run transfer always starts the map clearing sweep.
    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (s_tuser == CMD_RUN)) |=> (state_reg == ST_CLEAR))
        else $error("run command did not start the clearing sweep");
`endif

endmodule

`default_nettype wire
